>>> rtl/fmpm_pkg.sv
package fmpm_pkg;

   localparam int N_W         = 63;
   localparam int COUNT_W     = 30;
   localparam int BIT_W       = 6;
   localparam int PROD_W      = 2 * COUNT_W;
   localparam int REM_W       = COUNT_W + 2;
   localparam int MU_W        = COUNT_W + 1;
   localparam int SQ_ENTRIES  = 64;
   localparam int MAX_SCAN    = 63;

   // Latency of the modular multiplier, operand to result register.
   localparam int MODMUL_DEPTH = 5;
   localparam int CNT_W        = 3;

   localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

   // Barrett constant floor(2^60 / PRIME).
   localparam logic [MU_W-1:0] BARRETT_MU =
      MU_W'((64'd1 << PROD_W) / {34'd0, PRIME});

   typedef struct packed {
      logic [COUNT_W-1:0] hi;   // F(k+1)
      logic [COUNT_W-1:0] lo;   // F(k)
   } fib_pair_type;

   typedef fib_pair_type [SQ_ENTRIES-1:0] sq_table_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_FINAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             mul_done;
      logic             finish;
      logic [BIT_W-1:0] bit_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_small;
      logic bit_set;
   } dp_status_type;

   // Reduces a value below three times the prime.
   function automatic logic [COUNT_W-1:0] reduce3(input logic [REM_W-1:0] r);
      logic [REM_W:0] d1;
      logic [REM_W:0] d2;
      d1 = {1'b0, r} - {3'b0, PRIME};
      d2 = {1'b0, r} - {2'b0, PRIME, 1'b0};
      if (!d2[REM_W]) begin
         return d2[COUNT_W-1:0];
      end else if (!d1[REM_W]) begin
         return d1[COUNT_W-1:0];
      end else begin
         return r[COUNT_W-1:0];
      end
   endfunction

   // Remainder by the prime through shifted subtraction, for values below
   // the prime times 2^34. Only the constant table below uses it.
   function automatic logic [63:0] mod_prime(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] step;
      r = v;
      for (int s = 33; s >= 0; s--) begin
         step = {34'd0, PRIME} << s;
         if (r >= step) begin
            r = r - step;
         end
      end
      return r;
   endfunction

   // Entry k holds the matrix [[1,1],[1,0]] raised to 2^k, as the pair
   // (F(2^k+1), F(2^k)) modulo the prime, built by Fibonacci doubling.
   function automatic sq_table_type build_square_table();
      sq_table_type tbl;
      logic [63:0]  f1;
      logic [63:0]  f0;
      logic [63:0]  t1;
      logic [63:0]  t0;
      logic [63:0]  pr;
      f1 = 64'd1;
      f0 = 64'd1;
      pr = {34'd0, PRIME};
      for (int k = 0; k < SQ_ENTRIES; k++) begin
         tbl[k].hi = f1[COUNT_W-1:0];
         tbl[k].lo = f0[COUNT_W-1:0];
         t1 = mod_prime(f1 * f1 + f0 * f0);
         t0 = mod_prime(f0 * mod_prime(64'd2 * f1 + pr - f0));
         f1 = t1;
         f0 = t0;
      end
      return tbl;
   endfunction

   localparam sq_table_type SQ_TABLE = build_square_table();

endpackage

>>> rtl/fibonacci_mod_prime_matrix_power_top.sv
// Returns F(n+1) modulo 1000000007 for a 63-bit index n, the count of domino
// tilings of a 2-by-n strip. An index is taken when start is high while busy
// is low; busy stays high until the result has gone out. The result appears on
// rsp_count for exactly one cycle with rsp_valid high, and the receiver must
// take it then, since it cannot stall the block. Index 0 returns nothing and
// leaves busy low. Indices 1 and 2 pass from idle through the final state to the
// strobe. For larger n the block scans S = min(POWER_STEPS, 63) exponent bits of
// n-2, one per cycle while no multiply is pending; each set bit among them waits
// out the five-stage pipelined modular multiplier before the scan goes on, and
// the final state then leads to the strobe.
module fibonacci_mod_prime_matrix_power_top #(
   parameter int POWER_STEPS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fmpm_pkg::N_W-1:0]      req_n,
   output logic                          rsp_valid,
   output logic [fmpm_pkg::COUNT_W-1:0]  rsp_count
);
   import fmpm_pkg::*;

   ctrl_cmd_type   cmd;
   dp_status_type  status;

   fmpm_ctrl #(
      .POWER_STEPS(POWER_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fmpm_datapath u_datapath (
      .clock  (clock),
      .req_n  (req_n),
      .cmd    (cmd),
      .status (status),
      .result (rsp_count)
   );

endmodule

>>> rtl/fmpm_modmul.sv
module fmpm_modmul (
   input  logic                          clock,
   input  logic [fmpm_pkg::COUNT_W-1:0]  a,
   input  logic [fmpm_pkg::COUNT_W-1:0]  b,
   output logic [fmpm_pkg::COUNT_W-1:0]  y
);
   import fmpm_pkg::*;

   logic [PROD_W-1:0]     prod_ff;
   logic [2*MU_W-1:0]     quot_ff;
   logic [REM_W-1:0]      low1_ff;
   logic [REM_W-1:0]      low2_ff;
   logic [REM_W-1:0]      qp_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [COUNT_W-1:0]    y_ff;

   logic [MU_W-1:0]       quot_est;

   assign quot_est = quot_ff[2*MU_W-1:MU_W];

   // Barrett reduction: the estimate is short by at most two primes,
   // so the low 32 bits of the difference carry the whole remainder.
   always_ff @(posedge clock) begin
      prod_ff <= {{COUNT_W{1'b0}}, a} * {{COUNT_W{1'b0}}, b};
      quot_ff <= {{MU_W{1'b0}}, prod_ff[PROD_W-1:COUNT_W-1]} * {{MU_W{1'b0}}, BARRETT_MU};
      low1_ff <= prod_ff[REM_W-1:0];
      qp_ff   <= REM_W'({1'b0, quot_est} * {2'b0, PRIME});
      low2_ff <= low1_ff;
      rem_ff  <= low2_ff - qp_ff;
      y_ff    <= reduce3(rem_ff);
   end

   assign y = y_ff;

endmodule

>>> rtl/fmpm_datapath.sv
module fmpm_datapath (
   input  logic                          clock,
   input  logic [fmpm_pkg::N_W-1:0]      req_n,
   input  fmpm_pkg::ctrl_cmd_type        cmd,
   output fmpm_pkg::dp_status_type       status,
   output logic [fmpm_pkg::COUNT_W-1:0]  result
);
   import fmpm_pkg::*;

   logic [N_W-1:0]      ex_ff;
   logic [N_W-1:0]      ex_in;
   fib_pair_type        acc_ff;
   fib_pair_type        acc_in;
   logic [COUNT_W-1:0]  res_ff;
   logic [COUNT_W-1:0]  res_in;

   fib_pair_type        sq;
   logic [COUNT_W-1:0]  m11;
   logic [COUNT_W-1:0]  m00;
   logic [COUNT_W-1:0]  m10;
   logic [COUNT_W-1:0]  m01;
   logic [REM_W-1:0]    sum_hi;
   logic [REM_W-1:0]    sum_lo;
   fib_pair_type        prod_pair;

   assign sq = SQ_TABLE[cmd.bit_sel];

   fmpm_modmul u_mul_11 (.clock(clock), .a(acc_ff.hi), .b(sq.hi), .y(m11));
   fmpm_modmul u_mul_00 (.clock(clock), .a(acc_ff.lo), .b(sq.lo), .y(m00));
   fmpm_modmul u_mul_10 (.clock(clock), .a(acc_ff.hi), .b(sq.lo), .y(m10));
   fmpm_modmul u_mul_01 (.clock(clock), .a(acc_ff.lo), .b(sq.hi), .y(m01));

   // F(k+m+1) = F(k+1)F(m+1) + F(k)F(m)
   // F(k+m)   = F(k+1)F(m) + F(k)F(m+1) - F(k)F(m)
   always_comb begin
      sum_hi       = {2'b0, m11} + {2'b0, m00};
      sum_lo       = {2'b0, m10} + {2'b0, m01} + {2'b0, PRIME} - {2'b0, m00};
      prod_pair.hi = reduce3(sum_hi);
      prod_pair.lo = reduce3(sum_lo);
   end

   always_comb begin
      ex_in  = ex_ff;
      acc_in = acc_ff;
      res_in = res_ff;
      if (cmd.load) begin
         ex_in = req_n - N_W'(2);
         // Index one starts from the pair that makes the final sum equal one.
         if (req_n == N_W'(1)) begin
            acc_in.hi = '0;
            acc_in.lo = COUNT_W'(1);
         end else begin
            acc_in.hi = COUNT_W'(1);
            acc_in.lo = '0;
         end
      end else if (cmd.mul_done) begin
         acc_in = prod_pair;
      end
      if (cmd.finish) begin
         res_in = reduce3({1'b0, acc_ff.hi, 1'b0} + {2'b0, acc_ff.lo});
      end
   end

   always_ff @(posedge clock) begin
      ex_ff  <= ex_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   always_comb begin
      status.n_zero  = (req_n == '0);
      status.n_small = (req_n == N_W'(1)) || (req_n == N_W'(2));
      status.bit_set = ex_ff[cmd.bit_sel];
   end

   assign result = res_ff;

endmodule

>>> rtl/fmpm_ctrl.sv
module fmpm_ctrl #(
   parameter int POWER_STEPS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  fmpm_pkg::dp_status_type  status,
   output fmpm_pkg::ctrl_cmd_type   cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   import fmpm_pkg::*;

   // The exponent n-2 is 63 bits wide, so at most 63 bits matter.
   localparam int SCAN_BITS = (POWER_STEPS < MAX_SCAN) ? POWER_STEPS : MAX_SCAN;
   localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(SCAN_BITS - 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MODMUL_DEPTH - 1);

   state_type          state_ff;
   state_type          state_in;
   logic [BIT_W-1:0]   bit_ff;
   logic [BIT_W-1:0]   bit_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               last_bit;

   assign last_bit = (bit_ff == LAST_BIT);

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      cnt_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            bit_in = '0;
            if (start) begin
               if (status.n_zero) begin
                  state_in = ST_IDLE;
               end else if (status.n_small) begin
                  state_in = ST_FINAL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.bit_set) begin
               state_in = ST_MUL;
            end else if (last_bit) begin
               state_in = ST_FINAL;
            end else begin
               bit_in = bit_ff + BIT_W'(1);
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               if (last_bit) begin
                  state_in = ST_FINAL;
               end else begin
                  bit_in   = bit_ff + BIT_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FINAL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load     = 1'b0;
      cmd.mul_done = 1'b0;
      cmd.finish   = 1'b0;
      cmd.bit_sel  = bit_ff;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: begin
         end
         ST_MUL: begin
            cmd.mul_done = (cnt_ff == CNT_LAST);
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/fmpm_checker.sv
module fmpm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [fmpm_pkg::N_W-1:0]      req_n,
   input logic                          rsp_valid,
   input logic [fmpm_pkg::COUNT_W-1:0]  rsp_count
);
   import fmpm_pkg::*;

   // A result ends the transfer and frees the block for the next index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("result strobe not followed by idle");

   // Index zero must not start work: the block stays idle after it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_n == '0) |=> !busy)
      else $error("index zero started work");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_n == N_W'(1)) |=> ##1 (rsp_valid && rsp_count == COUNT_W'(1)))
      else $error("index one did not return one");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_n == N_W'(2)) |=> ##1 (rsp_valid && rsp_count == COUNT_W'(2)))
      else $error("index two did not return two");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count < PRIME))
      else $error("result not reduced below the prime");

endmodule

bind fibonacci_mod_prime_matrix_power_top fmpm_checker u_fmpm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_n     (req_n),
   .rsp_valid (rsp_valid),
   .rsp_count (rsp_count)
);
